// ===== design/remote_start_stop_module_unit_macros.svh =====
// Assertion macros shared by the remote start/stop controller.
// No dependencies; included by modules that carry concurrent checks.
`ifndef REMOTE_START_STOP_MODULE_UNIT_MACROS_SVH
`define REMOTE_START_STOP_MODULE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define RSSM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define RSSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rssm_pkg.sv =====
// Types and constants for the remote start/stop controller.
// No dependencies; imported by rssm_core and the top level.
package rssm_pkg;

    // Module status codes
    typedef enum logic [2:0] {
        MODE_POWER_ON    = 3'd0,
        MODE_STARTED     = 3'd1,
        MODE_STOPPED_SAFE = 3'd2,
        MODE_STOPPED     = 3'd3,
        MODE_PROGRAMMING = 3'd4
    } t_mode;

    // Input item kinds
    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_COMMAND = 2'd1,
        ACT_RESTORE = 2'd2,
        ACT_RESET   = 2'd3
    } t_action;

    // Configuration register indexes
    localparam logic [1:0] CFG_PROGRAM_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_START_ADDRESS   = 2'd1;
    localparam logic [1:0] CFG_COOLDOWN_TICKS  = 2'd2;

    // Configuration reset values
    localparam logic [7:0] PROGRAM_ADDRESS_RST = 8'd11;
    localparam logic [7:0] START_ADDRESS_RST   = 8'd7;
    localparam logic [7:0] COOLDOWN_TICKS_RST  = 8'd50;

    // Command byte masks
    localparam logic [7:0] RING_MASK = 8'hFE;
    localparam logic [7:0] START_BIT = 8'h01;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] ring;
        logic [7:0] wait_count;
    } t_state;

    typedef struct packed {
        logic [7:0] program_address;
        logic [7:0] start_address;
        logic [7:0] cooldown_ticks;
    } t_cfg;

    typedef struct packed {
        t_action    action;
        logic [7:0] cmd_address;
        logic [7:0] cmd_data;
        logic [2:0] restore_code;
        logic [7:0] saved_ring;
    } t_item;

endpackage

// ===== design/remote_start_stop_module_unit.sv =====
// Top level of the remote start/stop controller: state, config and output staging.
// Depends on rssm_pkg, rssm_core and remote_start_stop_module_unit_macros.svh.
//
// Channel   Dir  Handshake                    Content
// s_axis    in   s_axis_tvalid/tready         one item: kind in tuser, fields in tdata
// m_axis    out  m_axis_tvalid/tready         one result per item: status, ring id, save
// cfg       in   i_cfg_valid/o_cfg_ready      register index and 8-bit value
//
// One item is accepted per cycle while s_axis_tready is high; its result is valid the next
// cycle, in the skid if a result waits. The state update is a single compare-and-select
// pass on accept. A two-entry output stage (output register plus skid) keeps input accept
// open while one result waits; s_axis_tready drops only when both entries are full.
// Synchronous active-low reset returns the module to power-on, ring id zero.
`include "remote_start_stop_module_unit_macros.svh"

module remote_start_stop_module_unit
    import rssm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // cmd_address[7:0], cmd_data[15:8],
                                       // restore_code[18:16], saved_ring[26:19], zero pad
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // status[2:0], ring_id[10:3], save_request[11],
                                       // zero pad
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    t_state     r_state;
    t_state     n_state;
    t_cfg       r_cfg;
    t_item      item;
    logic       save;
    logic [11:0] result;

    logic        r_out_valid;
    logic [11:0] r_out_data;
    logic        r_skid_valid;
    logic [11:0] r_skid_data;

    logic in_fire;
    logic out_fire;
    logic cfg_fire;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign cfg_fire = i_cfg_valid && o_cfg_ready;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_skid_valid;

    // Unpack the input transaction
    assign item.action       = t_action'(s_axis_tuser);
    assign item.cmd_address  = s_axis_tdata[7:0];
    assign item.cmd_data     = s_axis_tdata[15:8];
    assign item.restore_code = s_axis_tdata[18:16];
    assign item.saved_ring   = s_axis_tdata[26:19];

    rssm_core u_core (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_item  (item),
        .o_state (n_state),
        .o_save  (save)
    );

    assign result = {save, n_state.ring, n_state.mode};

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.program_address <= PROGRAM_ADDRESS_RST;
            r_cfg.start_address   <= START_ADDRESS_RST;
            r_cfg.cooldown_ticks  <= COOLDOWN_TICKS_RST;
        end else if (cfg_fire) begin
            unique case (i_cfg_index)
                CFG_PROGRAM_ADDRESS: r_cfg.program_address <= i_cfg_data;
                CFG_START_ADDRESS:   r_cfg.start_address   <= i_cfg_data;
                CFG_COOLDOWN_TICKS:  r_cfg.cooldown_ticks  <= i_cfg_data;
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    // Controller state, advanced once per accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode       <= MODE_POWER_ON;
            r_state.ring       <= 8'd0;
            r_state.wait_count <= 8'd0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Output register and skid entry; the skid always holds the younger result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_fire) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_fire;
                end
            end else if (in_fire) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (in_fire) begin
                r_out_data <= result;
            end
        end
        if (in_fire && r_out_valid && !out_fire) begin
            r_skid_data <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_data};

    // Checks on the output staging and state update
    `RSSM_ASSERT_IMPLY(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid entry holds a result while the output register is empty")
    `RSSM_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, in_fire, m_axis_tvalid,
        "accepted transaction left no result")
    `RSSM_ASSERT_NEXT(a_stalled_accept_to_skid, i_clk, i_rst_n,
        in_fire && r_out_valid && !m_axis_tready, r_skid_valid,
        "transaction accepted behind a stalled result was not kept")
    `RSSM_ASSERT_NEXT(a_state_holds_idle, i_clk, i_rst_n, !in_fire, $stable(r_state),
        "controller state changed without an accepted transaction")

endmodule

// ===== design/rssm_core.sv =====
// Next-state and save-request logic of the remote start/stop controller.
// Depends on rssm_pkg; purely combinational, used by the top level.
module rssm_core
    import rssm_pkg::*;
(
    input  t_state i_state,
    input  t_cfg   i_cfg,
    input  t_item  i_item,
    output t_state o_state,
    output logic   o_save
);

    logic [7:0] id;
    logic       prog_hit;
    logic       start_hit;
    logic       wait_zero;

    assign id        = i_item.cmd_data & RING_MASK;
    assign prog_hit  = (i_item.cmd_address == i_cfg.program_address) &&
                       (i_state.mode == MODE_POWER_ON || i_state.mode == MODE_STARTED);
    assign start_hit = (i_item.cmd_address == i_cfg.start_address) && (id == i_state.ring);
    assign wait_zero = (i_state.wait_count == 8'd0);

    // Decode the item kind and update status, ring id and cooldown
    always_comb begin
        o_state = i_state;
        o_save  = 1'b0;
        unique case (i_item.action)
            ACT_TICK: begin
                if (wait_zero && i_state.mode == MODE_STOPPED_SAFE) begin
                    o_state.mode = MODE_STOPPED;
                    o_save       = 1'b1;
                end else if (wait_zero && i_state.mode == MODE_PROGRAMMING) begin
                    o_state.mode = MODE_POWER_ON;
                    o_save       = 1'b1;
                end
                if (!wait_zero) begin
                    o_state.wait_count = i_state.wait_count - 8'd1;
                end
            end
            ACT_COMMAND: begin
                if (prog_hit) begin
                    // Program a new ring id; an unchanged id is dropped
                    if (id != i_state.ring) begin
                        o_state.mode       = MODE_PROGRAMMING;
                        o_state.wait_count = i_cfg.cooldown_ticks;
                        o_state.ring       = id;
                        o_save             = 1'b1;
                    end
                end else if (start_hit) begin
                    if ((i_item.cmd_data & START_BIT) != 8'd0) begin
                        if (i_state.mode == MODE_POWER_ON) begin
                            o_state.mode = MODE_STARTED;
                        end
                    end else begin
                        o_state.mode       = MODE_STOPPED_SAFE;
                        o_state.wait_count = i_cfg.cooldown_ticks;
                    end
                    o_save = 1'b1;
                end
            end
            ACT_RESTORE: begin
                o_state.ring = i_item.saved_ring;
                if (i_item.restore_code == MODE_STARTED) begin
                    o_state.mode = MODE_STARTED;
                end else if (i_item.restore_code == MODE_STOPPED_SAFE) begin
                    o_state.mode       = MODE_STOPPED_SAFE;
                    o_state.wait_count = i_cfg.cooldown_ticks;
                end else begin
                    o_state.mode = MODE_POWER_ON;
                end
            end
            ACT_RESET: begin
                if (i_state.mode == MODE_STOPPED) begin
                    o_state.mode = MODE_POWER_ON;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule
